@@ hw/rtl/sse_pkg.sv @@
// Shared types and operation codes for the sorted set engine.
`default_nettype none
package sse_pkg;

   // Operation codes carried on req_func
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_MEMBER = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam int FUNC_W  = 2;
   localparam int REQ_KEY_W = 32;
   localparam int COUNT_W = 7;

   // Shift command broadcast to every cell in the apply cycle
   typedef struct packed {
      logic ins;
      logic rem;
   } shift_ctl_type;

   // Compare result held by each cell
   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage
`default_nettype wire

@@ hw/rtl/sse_cell.sv @@
// One storage cell of the sorted key chain: holds a key, compares, shifts.
`default_nettype none
module sse_cell #(
   parameter int KEY_BITS = 32,
   parameter int CW       = 7,
   parameter int IDX      = 0
) (
   input  wire logic                     clock,
   input  wire logic                     cmp_en,
   input  wire logic [KEY_BITS-1:0]      cmp_key,
   input  wire logic [CW-1:0]            count,
   input  wire sse_pkg::shift_ctl_type   ctl,
   input  wire logic [KEY_BITS-1:0]      ins_key,
   input  wire logic [KEY_BITS-1:0]      left_key,
   input  wire logic                     left_lt,
   input  wire logic [KEY_BITS-1:0]      right_key,
   output      sse_pkg::cell_flags_type  flags,
   output      logic [KEY_BITS-1:0]      key
);

   logic [KEY_BITS-1:0]     key_ff, key_in;
   sse_pkg::cell_flags_type flags_ff, flags_in;
   logic                    occupied;

   assign occupied = count > CW'(IDX);

   always_comb begin
      flags_in.lt = occupied && (key_ff < cmp_key);
      flags_in.eq = occupied && (key_ff == cmp_key);
   end

   // cells below the target position keep their key
   always_comb begin
      key_in = key_ff;
      if (ctl.ins && !flags_ff.lt) begin
         key_in = left_lt ? ins_key : left_key;
      end else if (ctl.rem && !flags_ff.lt) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (cmp_en) begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;
   assign key   = key_ff;

endmodule
`default_nettype wire

@@ hw/rtl/sorted_set_engine_unit.sv @@
// Top level of the sorted set engine: control, count and the cell chain.
//
// Usage: a transaction is accepted on the rising edge where start is high
// and busy is low; req_func selects insert, member query, remove or clear
// and req_key carries the key (its low KEY_BITS bits are used).
// In the accept cycle every cell compares its key against req_key and
// registers less-than and equal flags. In the following cycle busy is
// high, the equal flags are OR-ed into the found bit, and the chain
// shifts: on insert cells at and above the sorted position take the key
// from their lower neighbor (the cell at the position takes the new key),
// on remove they take the key from their upper neighbor.
// The result is registered at the end of the busy cycle and appears on
// the rsp_ ports in the next cycle, marked by a one-cycle rsp_valid strobe.
// No new transaction is taken while busy: each one needs the compare
// cycle followed by the shift cycle of the cell chain. start may be held
// high; it is taken whenever busy is low.
// Results cannot be stalled: the receiver must take each strobe.
// Reset (synchronous, active high) empties the set at once; stored keys
// are not cleared since only cells below the count are ever used.
`default_nettype none
module sorted_set_engine_unit #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output      logic                           busy,
   input  wire logic [sse_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [sse_pkg::REQ_KEY_W-1:0]  req_key,
   output      logic                           rsp_valid,
   output      logic                           rsp_found,
   output      logic                           rsp_changed,
   output      logic                           rsp_full_res,
   output      logic [sse_pkg::COUNT_W-1:0]    rsp_count
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic                          accept;
   logic [KEY_BITS-1:0]           cmp_key;

   // control registers
   logic                          busy_ff;
   logic [sse_pkg::FUNC_W-1:0]    func_ff;
   logic [KEY_BITS-1:0]           key_ff;
   logic [CW-1:0]                 count_ff, count_in;

   // response registers
   logic                          rsp_valid_ff;
   logic                          found_ff, found_in;
   logic                          changed_ff, changed_in;
   logic                          full_ff, full_in;
   logic [sse_pkg::COUNT_W-1:0]   rsp_count_ff;

   // chain wiring
   sse_pkg::cell_flags_type       flags [CAPACITY];
   logic [KEY_BITS-1:0]           keys  [CAPACITY];
   logic [CAPACITY-1:0]           eq_vec;
   sse_pkg::shift_ctl_type        ctl;
   logic                          present;
   logic                          at_cap;

   assign accept  = start && !busy_ff;
   assign cmp_key = KEY_BITS'(req_key);

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         eq_vec[i] = flags[i].eq;
      end
   end

   assign present = |eq_vec;
   assign at_cap  = count_ff == CW'(CAPACITY);

   // decide the operation outcome in the apply cycle
   always_comb begin
      ctl        = '0;
      count_in   = count_ff;
      found_in   = 1'b0;
      changed_in = 1'b0;
      full_in    = 1'b0;
      unique case (func_ff)
         sse_pkg::FUNC_INSERT: begin
            found_in = present;
            if (!present) begin
               if (at_cap) begin
                  full_in = 1'b1;
               end else begin
                  ctl.ins    = busy_ff;
                  count_in   = count_ff + CW'(1);
                  changed_in = 1'b1;
               end
            end
         end
         sse_pkg::FUNC_MEMBER: begin
            found_in = present;
         end
         sse_pkg::FUNC_REMOVE: begin
            found_in = present;
            if (present) begin
               ctl.rem    = busy_ff;
               count_in   = count_ff - CW'(1);
               changed_in = 1'b1;
            end
         end
         sse_pkg::FUNC_CLEAR: begin
            changed_in = count_ff != '0;
            count_in   = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy_ff;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            busy_ff  <= 1'b0;
            count_ff <= count_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         key_ff  <= cmp_key;
      end
      if (busy_ff) begin
         found_ff     <= found_in;
         changed_ff   <= changed_in;
         full_ff      <= full_in;
         rsp_count_ff <= sse_pkg::COUNT_W'(count_in);
      end
   end

   // row of cells, neighbors wired both ways
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_BITS-1:0] left_key;
      logic                left_lt;
      logic [KEY_BITS-1:0] right_key;

      if (g == 0) begin : g_first
         assign left_key = key_ff;
         assign left_lt  = 1'b1;
      end else begin : g_mid
         assign left_key = keys[g-1];
         assign left_lt  = flags[g-1].lt;
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_key = keys[g];
      end else begin : g_inner
         assign right_key = keys[g+1];
      end

      sse_cell #(
         .KEY_BITS (KEY_BITS),
         .CW       (CW),
         .IDX      (g)
      ) u_cell (
         .clock     (clock),
         .cmp_en    (accept),
         .cmp_key   (cmp_key),
         .count     (count_ff),
         .ctl       (ctl),
         .ins_key   (key_ff),
         .left_key  (left_key),
         .left_lt   (left_lt),
         .right_key (right_key),
         .flags     (flags[g]),
         .key       (keys[g])
      );
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_changed  = changed_ff;
   assign rsp_full_res = full_ff;
   assign rsp_count    = rsp_count_ff;

endmodule
`default_nettype wire

@@ test/sorted_set_engine_unit_tb.sv @@
// Self-checking testbench for the sorted set engine against a key-set scoreboard.
`timescale 1ns / 1ps
module sorted_set_engine_unit_tb;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 32;
   // random transactions to send after the directed part
   localparam int ITEMS = 1350;
   // cycles with no transaction on either side before the run is called hung
   localparam int STALL_LIMIT = 2000;
   localparam logic [sse_pkg::REQ_KEY_W-1:0] KEY_MASK =
      {sse_pkg::REQ_KEY_W{1'b1}} >> (sse_pkg::REQ_KEY_W - KEY_BITS);

   typedef logic [sse_pkg::REQ_KEY_W-1:0] key_type;
   typedef logic [sse_pkg::FUNC_W-1:0] func_type;

   typedef struct packed {
      logic                        found;
      logic                        changed;
      logic                        full_res;
      logic [sse_pkg::COUNT_W-1:0] count;
   } set_outcome_type;

   // Scoreboard: keeps its own sorted copy of the set, predicts one outcome per
   // accepted transaction and checks outcomes in order.
   class key_set_model_type;
      key_type         keys[$];              // ascending, distinct
      set_outcome_type pending_outcomes[$];
      int unsigned     n_fail;

      function int unsigned held();
         return keys.size();
      endfunction

      function int unsigned waiting();
         return pending_outcomes.size();
      endfunction

      // first slot whose key is not below k
      function int unsigned lower_pos(key_type k);
         int unsigned i;
         i = 0;
         while (i < keys.size() && keys[i] < k) i++;
         return i;
      endfunction

      function key_type any_held_key();
         if (keys.size() == 0) return $urandom;
         return keys[$urandom_range(0, keys.size() - 1)];
      endfunction

      // keys biased toward hits, neighbors of hits, small values and the extremes
      function key_type pick_key();
         key_type k;
         case ($urandom_range(0, 9))
            0, 1, 2: k = any_held_key();
            3: begin
               k = any_held_key();
               if ($urandom_range(0, 1) != 0) k = k + 1;
               else k = k - 1;
            end
            4, 5: k = $urandom_range(0, 15);
            6: begin
               case ($urandom_range(0, 3))
                  0: k = '0;
                  1: k = '1;
                  2: k = 32'h8000_0000;
                  default: k = 32'h7FFF_FFFF;
               endcase
            end
            default: k = $urandom;
         endcase
         return k;
      endfunction

      function void note_request(func_type func, key_type raw_key);
         key_type         k;
         int unsigned     pos;
         logic            present;
         set_outcome_type o;
         k = raw_key & KEY_MASK;
         pos = lower_pos(k);
         present = (pos < keys.size()) && (keys[pos] == k);
         o = '0;
         case (func)
            sse_pkg::FUNC_INSERT: begin
               o.found = present;
               if (!present) begin
                  if (keys.size() >= CAPACITY) begin
                     o.full_res = 1'b1;
                  end else begin
                     keys.insert(pos, k);
                     o.changed = 1'b1;
                  end
               end
            end
            sse_pkg::FUNC_MEMBER: o.found = present;
            sse_pkg::FUNC_REMOVE: begin
               o.found = present;
               if (present) begin
                  keys.delete(pos);
                  o.changed = 1'b1;
               end
            end
            default: begin
               o.changed = keys.size() != 0;
               keys.delete();
            end
         endcase
         o.count = sse_pkg::COUNT_W'(keys.size());
         pending_outcomes.push_back(o);
      endfunction

      function void mismatch(string field, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         n_fail++;
      endfunction

      function void check_outcome(logic found, logic changed, logic full_res,
                                  logic [sse_pkg::COUNT_W-1:0] count);
         set_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %s=%0b %s=%0b %s=%0b %s=%0d",
                     $time, "found", found, "changed", changed, "full_res", full_res,
                     "count", count);
            n_fail++;
            return;
         end
         want = pending_outcomes.pop_front();
         if (found !== want.found) mismatch("found", want.found, found);
         if (changed !== want.changed) mismatch("changed", want.changed, changed);
         if (full_res !== want.full_res) mismatch("full_res", want.full_res, full_res);
         if (count !== want.count) mismatch("count", want.count, count);
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   func_type                    req_func;
   key_type                     req_key;
   logic                        rsp_valid;
   logic                        rsp_found;
   logic                        rsp_changed;
   logic                        rsp_full_res;
   logic [sse_pkg::COUNT_W-1:0] rsp_count;

   key_set_model_type model;
   int unsigned       n_sent;
   int unsigned       quiet_cycles;

   sorted_set_engine_unit #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_func    (req_func),
      .req_key     (req_key),
      .rsp_valid   (rsp_valid),
      .rsp_found   (rsp_found),
      .rsp_changed (rsp_changed),
      .rsp_full_res(rsp_full_res),
      .rsp_count   (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: the strobe lasts one cycle and cannot be held off, so every
   // edge with rsp_valid high is a transaction. Values read here are the
   // pre-edge ones since the block updates them with nonblocking assignments.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         model.check_outcome(rsp_found, rsp_changed, rsp_full_res, rsp_count);
      end
   end

   // Hang detector: any accepted transaction or result restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Present one transaction and hold it until the block takes it. Called right
   // after a rising edge; returns at the edge where the transaction happened,
   // with start still high so the next one can follow back to back.
   task automatic send_op(input func_type func, input key_type key);
      start    <= 1'b1;
      req_func <= func;
      req_key  <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      model.note_request(func, key);
      n_sent++;
   endtask

   // Sender gap: start low, junk on the request fields to show they are ignored.
   task automatic pause(input int unsigned n);
      if (n != 0) begin
         start    <= 1'b0;
         req_func <= func_type'($urandom);
         req_key  <= $urandom;
         repeat (n) @(posedge clock);
      end
   endtask

   // mostly back to back or short gaps, now and then a long one
   function automatic int unsigned gap_len(input bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic do_op(input func_type func, input key_type key, input bit steady);
      send_op(func, key);
      pause(gap_len(steady));
   endtask

   // Hold the sender off until every outstanding result is back.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (model.waiting() != 0) @(posedge clock);
   endtask

   // Clear, fill to capacity, then poke at the full set: refused inserts,
   // present-key inserts, queries and remove/refill pairs.
   task automatic fill_burst(input bit steady);
      int unsigned tries;
      do_op(sse_pkg::FUNC_CLEAR, model.pick_key(), steady);
      tries = 0;
      while (model.held() < CAPACITY && tries < 200) begin
         if ($urandom_range(0, 3) == 0) do_op(sse_pkg::FUNC_INSERT, model.pick_key(), steady);
         else do_op(sse_pkg::FUNC_INSERT, $urandom, steady);
         tries++;
      end
      repeat (12) begin
         case ($urandom_range(0, 3))
            0: do_op(sse_pkg::FUNC_INSERT, $urandom, steady);
            1: do_op(sse_pkg::FUNC_INSERT, model.any_held_key(), steady);
            2: do_op(sse_pkg::FUNC_MEMBER, model.pick_key(), steady);
            default: begin
               do_op(sse_pkg::FUNC_REMOVE, model.any_held_key(), steady);
               do_op(sse_pkg::FUNC_INSERT, model.pick_key(), steady);
            end
         endcase
      end
   endtask

   // Empty the set key by key, then hit the empty set once more.
   task automatic drain_burst(input bit steady);
      while (model.held() != 0) begin
         if ($urandom_range(0, 4) == 0) do_op(sse_pkg::FUNC_MEMBER, model.pick_key(), steady);
         else do_op(sse_pkg::FUNC_REMOVE, model.any_held_key(), steady);
      end
      do_op(sse_pkg::FUNC_REMOVE, model.pick_key(), steady);
   endtask

   task automatic mixed_burst(input bit steady);
      int unsigned len;
      int unsigned r;
      func_type    f;
      len = $urandom_range(20, 60);
      repeat (len) begin
         r = $urandom_range(0, 99);
         if (r < 40) f = sse_pkg::FUNC_INSERT;
         else if (r < 65) f = sse_pkg::FUNC_MEMBER;
         else if (r < 98) f = sse_pkg::FUNC_REMOVE;
         else f = sse_pkg::FUNC_CLEAR;
         do_op(f, model.pick_key(), steady);
      end
   endtask

   initial begin
      int unsigned kind;
      bit          steady;
      model = new();
      n_sent = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_func <= sse_pkg::FUNC_INSERT;
      req_key  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: every op on the empty set, key extremes, insert at the
      // back and in the middle, duplicate insert, hit and miss on query and
      // remove, removal of first and last, clear of a populated set.
      do_op(sse_pkg::FUNC_MEMBER, 32'h0000_0000, 1'b0);
      do_op(sse_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 1'b0);
      do_op(sse_pkg::FUNC_CLEAR, 32'h0000_0000, 1'b0);
      do_op(sse_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0);
      do_op(sse_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 1'b0);
      do_op(sse_pkg::FUNC_INSERT, 32'h8000_0000, 1'b0);
      do_op(sse_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b0);
      do_op(sse_pkg::FUNC_INSERT, 32'h0000_0001, 1'b0);
      do_op(sse_pkg::FUNC_INSERT, 32'h7FFF_FFFE, 1'b0);
      do_op(sse_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0);
      do_op(sse_pkg::FUNC_MEMBER, 32'hFFFF_FFFF, 1'b0);
      do_op(sse_pkg::FUNC_MEMBER, 32'h0000_0005, 1'b0);
      do_op(sse_pkg::FUNC_REMOVE, 32'h8000_0000, 1'b0);
      do_op(sse_pkg::FUNC_REMOVE, 32'h8000_0000, 1'b0);
      do_op(sse_pkg::FUNC_REMOVE, 32'h0000_0000, 1'b0);
      do_op(sse_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 1'b0);
      do_op(sse_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 1'b0);
      do_op(sse_pkg::FUNC_CLEAR, 32'h0000_0000, 1'b0);
      wait_for_results();

      // Random bursts; about a quarter run without sender gaps.
      while (n_sent < ITEMS + 20) begin
         steady = $urandom_range(0, 3) == 0;
         kind = $urandom_range(0, 9);
         if (kind < 2) fill_burst(steady);
         else if (kind < 3) drain_burst(steady);
         else mixed_burst(steady);
         if ($urandom_range(0, 3) == 0) wait_for_results();
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (model.n_fail == 0 && model.waiting() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/sse_pkg.sv
hw/rtl/sse_cell.sv
hw/rtl/sorted_set_engine_unit.sv
test/sorted_set_engine_unit_tb.sv
